@@ hw/rtl/sfoe_pkg.sv @@
// ----------------------------------------------------------------------------
// sfoe_pkg
// Shared widths, register indexes, word types and helpers for the spectral
// flux onset envelope core.
// ----------------------------------------------------------------------------
package sfoe_pkg;

	// field and state widths
	localparam int SAMPLE_BITS = 16;
	localparam int MAG_W       = SAMPLE_BITS;
	localparam int SQ_W        = 2 * SAMPLE_BITS;
	localparam int BIN_W       = 11;
	localparam int FLUX_W      = 26;
	localparam int ENERGY_W    = 42;
	localparam int GATE_W      = 16;
	localparam int LIMIT_W     = 2 * GATE_W + BIN_W;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// default transform length
	localparam int FFT_LEN_DEF = 2048;

	// reset values and saturation limits
	localparam logic [BIN_W-1:0]    FIRST_BIN_RST = 11'd0;
	localparam logic [BIN_W-1:0]    END_BIN_RST   = 11'd1025;
	localparam logic [GATE_W-1:0]   GATE_RST      = 16'd0;
	localparam logic [BIN_W-1:0]    BIN_MAX       = 11'h7FF;
	localparam logic [FLUX_W-1:0]   FLUX_MAX      = 26'h3FF_FFFF;
	localparam logic [ENERGY_W-1:0] ENERGY_MAX    = 42'h3FF_FFFF_FFFF;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIRST_BIN   = 2'd0,
		REG_END_BIN     = 2'd1,
		REG_ENERGY_GATE = 2'd2
	} cfg_reg_t;

	// input word: one bin
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] real_part;
		logic signed [SAMPLE_BITS-1:0] imag_part;
		logic                          frame_end;
	} sfoe_in_t;

	// output word: one frame result
	typedef struct packed {
		logic [FLUX_W-1:0] frame_flux;
		logic              frame_gated;
	} sfoe_out_t;

	// magnitude of a two's complement sample, most negative value maps to 2^(n-1)
	function automatic logic [SAMPLE_BITS-1:0] abs_sample(
		input logic signed [SAMPLE_BITS-1:0] v
	);
		return v[SAMPLE_BITS-1] ? SAMPLE_BITS'(-v) : SAMPLE_BITS'(v);
	endfunction

endpackage

@@ hw/rtl/spectral_flux_onset_envelope_core.sv @@
// ----------------------------------------------------------------------------
// spectral_flux_onset_envelope_core
// Half-wave rectified spectral flux per frame with an RMS energy gate; the
// previous frame's magnitudes live in one synchronous memory.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              word
//  bin       in         bin_valid/bin_ready    sfoe_in_t  (one STFT bin)
//  flux      out        flux_valid/flux_ready  sfoe_out_t (one per frame)
//  cfg       in         cfg_we                 cfg_addr, cfg_wdata
//
//  a bin runs from its accept through the memory read and squares, the
//  2-bit-per-cycle square root (eight steps and a done pulse) and the
//  read-modify-write of the magnitude memory, then back to idle; the next
//  bin is accepted only in idle.
//  the last bin of a frame adds the gate product and the result load.
//  after reset the magnitude memory is cleared, one entry a cycle, over
//  all FFT_LEN/2+1 entries (1025 by default); bin_ready stays low meanwhile.
//  a held result stalls only the end of the next frame, not its bins.
// ----------------------------------------------------------------------------
module spectral_flux_onset_envelope_core #(
	parameter int FFT_LEN = sfoe_pkg::FFT_LEN_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            bin_valid,
	output logic                            bin_ready,
	input  sfoe_pkg::sfoe_in_t              bin_data,
	output logic                            flux_valid,
	input  logic                            flux_ready,
	output sfoe_pkg::sfoe_out_t             flux_data,
	input  logic                            cfg_we,
	input  logic [sfoe_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [sfoe_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import sfoe_pkg::*;

	localparam int NUM_BINS = FFT_LEN / 2 + 1;
	localparam int AW       = $clog2(NUM_BINS);

	typedef enum logic [6:0] {
		S_CLEAR  = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_SQUARE = 7'b0000100,
		S_ROOT   = 7'b0001000,
		S_UPDATE = 7'b0010000,
		S_GATE   = 7'b0100000,
		S_EMIT   = 7'b1000000
	} state_t;

	state_t state_q;

	logic [BIN_W-1:0]    first_bin_q, end_bin_q;
	logic [GATE_W-1:0]   gate_q;
	logic [2*GATE_W-1:0] gate_sq_q;

	logic [BIN_W-1:0]    bin_cnt_q, bins_q;
	logic [FLUX_W-1:0]   flux_q;
	logic [ENERGY_W-1:0] energy_q;
	logic [AW-1:0]       clr_addr_q;

	logic [MAG_W-1:0]    re_abs_q, im_abs_q;
	logic                fe_q, in_range_q;
	logic [AW-1:0]       addr_q;
	logic [MAG_W-1:0]    prev_q, mag_q;
	logic [SQ_W-1:0]     sq_q;
	logic [LIMIT_W-1:0]  limit_q;

	logic                flux_valid_q;
	sfoe_out_t           flux_data_q;

	logic [MAG_W-1:0]    mag_mem [NUM_BINS];
	logic [MAG_W-1:0]    rd_data_q;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [MAG_W-1:0]    mem_wdata;

	logic                bin_accept, in_range, out_free, emit_load, gated;
	logic [SQ_W-1:0]     re_sq, im_sq, sq_sum;
	logic                root_done;
	logic [MAG_W-1:0]    root;
	logic [FLUX_W:0]     flux_add;
	logic [ENERGY_W:0]   energy_add;
	logic [FLUX_W-1:0]   flux_next;
	logic [ENERGY_W-1:0] energy_next;

	// handshakes
	assign bin_ready  = (state_q == S_IDLE);
	assign bin_accept = bin_valid && bin_ready;
	assign out_free   = !flux_valid_q || flux_ready;
	assign emit_load  = (state_q == S_EMIT) && out_free;

	// bin range test on the running bin index
	assign in_range = (bin_cnt_q >= first_bin_q) && (bin_cnt_q < end_bin_q)
		&& (int'(bin_cnt_q) < NUM_BINS);

	// squared magnitude
	assign re_sq  = re_abs_q * re_abs_q;
	assign im_sq  = im_abs_q * im_abs_q;
	assign sq_sum = re_sq + im_sq;

	sfoe_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_SQUARE),
		.radicand (sq_sum),
		.done     (root_done),
		.root     (root)
	);

	// saturating accumulators
	always_comb begin
		flux_add   = {1'b0, flux_q};
		if (mag_q > prev_q) begin
			flux_add = {1'b0, flux_q} + (FLUX_W+1)'(mag_q - prev_q);
		end
		flux_next   = flux_add[FLUX_W] ? FLUX_MAX : flux_add[FLUX_W-1:0];
		energy_add  = {1'b0, energy_q} + (ENERGY_W+1)'(sq_q);
		energy_next = energy_add[ENERGY_W] ? ENERGY_MAX : energy_add[ENERGY_W-1:0];
	end

	// energy gate decision
	assign gated = (bins_q != '0) && ({1'b0, energy_q} < limit_q);

	// memory write port: clearing pass or magnitude update
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = mag_q;
		if (state_q == S_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else if (state_q == S_UPDATE) begin
			mem_we = in_range_q;
		end
	end

	// previous magnitude memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mag_mem[mem_waddr] <= mem_wdata;
		end
		if (bin_accept) begin
			rd_data_q <= mag_mem[AW'(bin_cnt_q)];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_bin_q <= FIRST_BIN_RST;
			end_bin_q   <= END_BIN_RST;
			gate_q      <= GATE_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_FIRST_BIN:   first_bin_q <= cfg_wdata[BIN_W-1:0];
				REG_END_BIN:     end_bin_q   <= cfg_wdata[BIN_W-1:0];
				REG_ENERGY_GATE: gate_q      <= cfg_wdata[GATE_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_addr_q   <= '0;
			bin_cnt_q    <= '0;
			bins_q       <= '0;
			flux_q       <= '0;
			energy_q     <= '0;
			flux_valid_q <= 1'b0;
		end else begin
			if (emit_load) begin
				flux_valid_q <= 1'b1;
			end else if (flux_ready) begin
				flux_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == AW'(NUM_BINS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (bin_accept) begin
						state_q <= S_SQUARE;
					end
				end
				S_SQUARE: begin
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					if (root_done) begin
						state_q <= S_UPDATE;
					end
				end
				S_UPDATE: begin
					if (in_range_q) begin
						flux_q   <= flux_next;
						energy_q <= energy_next;
						if (bins_q != BIN_MAX) begin
							bins_q <= bins_q + 1'b1;
						end
					end
					if (bin_cnt_q != BIN_MAX) begin
						bin_cnt_q <= bin_cnt_q + 1'b1;
					end
					state_q <= fe_q ? S_GATE : S_IDLE;
				end
				S_GATE: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						bin_cnt_q <= '0;
						bins_q    <= '0;
						flux_q    <= '0;
						energy_q  <= '0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item datapath registers
	always_ff @(posedge clk) begin
		gate_sq_q <= gate_q * gate_q;
		if (bin_accept) begin
			re_abs_q   <= abs_sample(bin_data.real_part);
			im_abs_q   <= abs_sample(bin_data.imag_part);
			fe_q       <= bin_data.frame_end;
			in_range_q <= in_range;
			addr_q     <= AW'(bin_cnt_q);
		end
		if (state_q == S_SQUARE) begin
			sq_q   <= sq_sum;
			prev_q <= rd_data_q;
		end
		if ((state_q == S_ROOT) && root_done) begin
			mag_q <= root;
		end
		if (state_q == S_GATE) begin
			limit_q <= gate_sq_q * bins_q;
		end
		if (emit_load) begin
			flux_data_q.frame_flux  <= gated ? '0 : flux_q;
			flux_data_q.frame_gated <= gated;
		end
	end

	assign flux_valid = flux_valid_q;
	assign flux_data  = flux_data_q;

	// checks
	a_gated_zero: assert property (@(posedge clk) disable iff (!arst_n)
		flux_valid |-> !(flux_data.frame_gated && (flux_data.frame_flux != '0)))
		else $error("gated frame carries nonzero flux");

	a_bins_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		bins_q <= bin_cnt_q)
		else $error("in-range count exceeds bin index");

	a_root_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		root_done |-> (state_q == S_ROOT))
		else $error("square root finished outside its wait state");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> (!flux_valid && !bin_ready))
		else $error("channel active during memory clear");

endmodule

@@ hw/rtl/sfoe_isqrt.sv @@
// ----------------------------------------------------------------------------
// sfoe_isqrt
// Iterative floor square root, two result bits per cycle, restoring
// digit recurrence over the squared magnitude.
// ----------------------------------------------------------------------------
module sfoe_isqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [sfoe_pkg::SQ_W-1:0] radicand,
	output logic                      done,
	output logic [sfoe_pkg::MAG_W-1:0] root
);
	import sfoe_pkg::*;

	localparam int STEPS = 2;
	localparam int ITER  = MAG_W / STEPS;
	localparam int CNT_W = $clog2(ITER + 1);
	localparam int REM_W = MAG_W + 4;

	logic [SQ_W-1:0]  x_q, x_n;
	logic [REM_W-1:0] rem_q, rem_n, trial;
	logic [MAG_W-1:0] root_q, root_n;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;

	// two recurrence steps per cycle
	always_comb begin
		x_n    = x_q;
		rem_n  = rem_q;
		root_n = root_q;
		trial  = '0;
		for (int k = 0; k < STEPS; k++) begin
			rem_n = {rem_n[REM_W-3:0], x_n[SQ_W-1 -: 2]};
			x_n   = x_n << 2;
			trial = {{(REM_W-MAG_W-2){1'b0}}, root_n, 2'b01};
			if (rem_n >= trial) begin
				rem_n  = rem_n - trial;
				root_n = {root_n[MAG_W-2:0], 1'b1};
			end else begin
				root_n = {root_n[MAG_W-2:0], 1'b0};
			end
		end
	end

	// iteration counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(ITER);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			x_q    <= x_n;
			rem_q  <= rem_n;
			root_q <= root_n;
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
